FILE: hdl/cursor_list_engine_defines.svh
// Assertion macros for the cursor list engine.
// Used by the top level only; no other dependency.
`ifndef CURSOR_LIST_ENGINE_DEFINES_SVH
`define CURSOR_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cle_pkg.sv
// Shared types for the cursor list engine: op and status codes,
// controller-to-datapath command and datapath-to-controller flag structs. No dependencies.
package cle_pkg;

  typedef enum logic [3:0] {
    OP_PREPEND   = 4'd0,
    OP_APPEND    = 4'd1,
    OP_INS_B     = 4'd2,
    OP_INS_A     = 4'd3,
    OP_DEL_FRONT = 4'd4,
    OP_DEL_BACK  = 4'd5,
    OP_DEL_CUR   = 4'd6,
    OP_MV_FRONT  = 4'd7,
    OP_MV_BACK   = 4'd8,
    OP_MV_PREV   = 4'd9,
    OP_MV_NEXT   = 4'd10,
    OP_SET       = 4'd11,
    OP_CLEAR     = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOCUR = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // link / address sources
  typedef enum logic [2:0] {
    LS_NIL  = 3'd0,
    LS_HEAD = 3'd1,
    LS_TAIL = 3'd2,
    LS_CUR  = 3'd3,
    LS_SLOT = 3'd4,
    LS_PN   = 3'd5,
    LS_NN   = 3'd6
  } lsel_t;

  typedef enum logic [3:0] {
    U_NONE      = 4'd0,
    U_PREPEND   = 4'd1,
    U_APPEND    = 4'd2,
    U_INS_B     = 4'd3,
    U_INS_A     = 4'd4,
    U_DEL_FRONT = 4'd5,
    U_DEL_BACK  = 4'd6,
    U_DEL_MID   = 4'd7,
    U_MV_FRONT  = 4'd8,
    U_MV_BACK   = 4'd9,
    U_MV_PREV   = 4'd10,
    U_MV_NEXT   = 4'd11,
    U_CUR_NIL   = 4'd12,
    U_CLEAR     = 4'd13
  } upd_t;

  typedef struct packed {
    logic    load;
    logic    alloc;
    lsel_t   rd_sel;
    logic    cap;
    logic    dwe;
    lsel_t   dw_sel;
    logic    nwe;
    lsel_t   nw_addr;
    lsel_t   nw_data;
    logic    pwe;
    lsel_t   pw_addr;
    lsel_t   pw_data;
    upd_t    upd;
    logic    free_en;
    lsel_t   free_sel;
    logic    st_we;
    status_t st;
    lsel_t   drd_sel;
    logic    cap_front;
    logic    cap_back;
    logic    cap_cur;
    logic    publish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic one;
    logic full;
    logic nocur;
    logic cur_head;
    logic cur_tail;
    logic cidx_zero;
    logic cidx_last;
    logic out_busy;
  } flags_t;

endpackage

FILE: hdl/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/cle_datapath.sv
// Datapath of the cursor list engine: list registers, node memories,
// free-slot stack and the result register. Uses cle_pkg and cle_ram.
module cle_datapath #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cle_pkg::cmd_t       cmd,
  output cle_pkg::flags_t     flags,
  input  logic [3:0]          in_op,
  input  logic signed [31:0]  in_value,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [6:0]          out_count,
  output logic signed [6:0]   out_cursor_pos,
  output logic signed [31:0]  out_front_value,
  output logic signed [31:0]  out_back_value,
  output logic signed [31:0]  out_cursor_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int DW = DATA_WIDTH;
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  logic [LW-1:0] head_r, tail_r, cur_r, cnt_r, cidx_r, hwm_r, sp_r, slot_r;
  logic [LW-1:0] pn_r, nn_r;
  logic [3:0]    op_r;
  logic [DW-1:0] val_r, fv_r, bv_r, cv_r;
  logic [1:0]    st_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [6:0]    out_count_r, out_cpos_r;
  logic [31:0]   out_fv_r, out_bv_r, out_cv_r;

  logic [DW-1:0] data_q;
  logic [LW-1:0] nx_q, pv_q;
  logic [AW-1:0] fs_q;

  logic [95:0]    val_ext;
  logic [LW+7:0]  cnt_ext, cidx_ext;
  logic [DW+31:0] fv_ext, bv_ext, cv_ext;
  logic [LW-1:0]  sp_m1, nw_data, pw_data, nw_addr, pw_addr, dw_addr, rd_addr;
  logic [LW-1:0]  drd_addr, free_slot;

  function automatic logic [LW-1:0] pick(cle_pkg::lsel_t s, logic [LW-1:0] h,
                                         logic [LW-1:0] t, logic [LW-1:0] c,
                                         logic [LW-1:0] sl, logic [LW-1:0] p,
                                         logic [LW-1:0] n);
    logic [LW-1:0] r;
    case (s)
      cle_pkg::LS_HEAD: r = h;
      cle_pkg::LS_TAIL: r = t;
      cle_pkg::LS_CUR:  r = c;
      cle_pkg::LS_SLOT: r = sl;
      cle_pkg::LS_PN:   r = p;
      cle_pkg::LS_NN:   r = n;
      default:          r = LW'(DEPTH);
    endcase
    return r;
  endfunction

  assign nw_data   = pick(cmd.nw_data, head_r, tail_r, cur_r, slot_r, pn_r, nn_r);
  assign pw_data   = pick(cmd.pw_data, head_r, tail_r, cur_r, slot_r, pn_r, nn_r);
  assign nw_addr   = pick(cmd.nw_addr, head_r, tail_r, cur_r, slot_r, pn_r, nn_r);
  assign pw_addr   = pick(cmd.pw_addr, head_r, tail_r, cur_r, slot_r, pn_r, nn_r);
  assign dw_addr   = pick(cmd.dw_sel, head_r, tail_r, cur_r, slot_r, pn_r, nn_r);
  assign rd_addr   = pick(cmd.rd_sel, head_r, tail_r, cur_r, slot_r, pn_r, nn_r);
  assign drd_addr  = pick(cmd.drd_sel, head_r, tail_r, cur_r, slot_r, pn_r, nn_r);
  assign free_slot = pick(cmd.free_sel, head_r, tail_r, cur_r, slot_r, pn_r, nn_r);
  assign sp_m1     = sp_r - LW'(1);

  cle_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data (
    .clk, .we(cmd.dwe), .waddr(dw_addr[AW-1:0]), .wdata(val_r),
    .raddr(drd_addr[AW-1:0]), .rdata(data_q)
  );

  cle_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_next (
    .clk, .we(cmd.nwe), .waddr(nw_addr[AW-1:0]), .wdata(nw_data),
    .raddr(rd_addr[AW-1:0]), .rdata(nx_q)
  );

  cle_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_prev (
    .clk, .we(cmd.pwe), .waddr(pw_addr[AW-1:0]), .wdata(pw_data),
    .raddr(rd_addr[AW-1:0]), .rdata(pv_q)
  );

  cle_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_free (
    .clk, .we(cmd.free_en), .waddr(sp_r[AW-1:0]), .wdata(free_slot[AW-1:0]),
    .raddr(sp_m1[AW-1:0]), .rdata(fs_q)
  );

  assign flags.op        = cle_pkg::op_t'(op_r);
  assign flags.empty     = (cnt_r == '0);
  assign flags.one       = (cnt_r == LW'(1));
  assign flags.full      = (cnt_r == NIL);
  assign flags.nocur     = (cur_r == NIL);
  assign flags.cur_head  = (cur_r == head_r);
  assign flags.cur_tail  = (cur_r == tail_r);
  assign flags.cidx_zero = (cidx_r == '0);
  assign flags.cidx_last = (cidx_r == cnt_r - LW'(1));
  assign flags.out_busy  = out_valid_r && out_stall;

  // list control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL;
      tail_r <= NIL;
      cur_r  <= NIL;
      cnt_r  <= '0;
      cidx_r <= '0;
      hwm_r  <= '0;
      sp_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.alloc) begin
        if (sp_r != '0) begin
          sp_r <= sp_m1;
        end else begin
          hwm_r <= hwm_r + LW'(1);
        end
      end
      if (cmd.free_en) begin
        sp_r <= sp_r + LW'(1);
      end
      case (cmd.upd)
        cle_pkg::U_PREPEND: begin
          head_r <= slot_r;
          if (cnt_r == '0) tail_r <= slot_r;
          if (cur_r != NIL) cidx_r <= cidx_r + LW'(1);
          cnt_r <= cnt_r + LW'(1);
        end
        cle_pkg::U_APPEND: begin
          tail_r <= slot_r;
          if (cnt_r == '0) head_r <= slot_r;
          cnt_r <= cnt_r + LW'(1);
        end
        cle_pkg::U_INS_B: begin
          cidx_r <= cidx_r + LW'(1);
          cnt_r  <= cnt_r + LW'(1);
        end
        cle_pkg::U_INS_A: begin
          cnt_r <= cnt_r + LW'(1);
        end
        cle_pkg::U_DEL_FRONT: begin
          if (cur_r == head_r) begin
            cur_r <= NIL;
          end else if (cur_r != NIL) begin
            cidx_r <= cidx_r - LW'(1);
          end
          if (cnt_r != LW'(1)) begin
            head_r <= nn_r;
          end else begin
            head_r <= NIL;
            tail_r <= NIL;
          end
          cnt_r <= cnt_r - LW'(1);
        end
        cle_pkg::U_DEL_BACK: begin
          if (cur_r == tail_r) cur_r <= NIL;
          if (cnt_r != LW'(1)) begin
            tail_r <= pn_r;
          end else begin
            head_r <= NIL;
            tail_r <= NIL;
          end
          cnt_r <= cnt_r - LW'(1);
        end
        cle_pkg::U_DEL_MID: begin
          cur_r <= NIL;
          cnt_r <= cnt_r - LW'(1);
        end
        cle_pkg::U_MV_FRONT: begin
          cur_r  <= head_r;
          cidx_r <= '0;
        end
        cle_pkg::U_MV_BACK: begin
          cur_r  <= tail_r;
          cidx_r <= cnt_r - LW'(1);
        end
        cle_pkg::U_MV_PREV: begin
          cur_r  <= pv_q;
          cidx_r <= cidx_r - LW'(1);
        end
        cle_pkg::U_MV_NEXT: begin
          cur_r  <= nx_q;
          cidx_r <= cidx_r + LW'(1);
        end
        cle_pkg::U_CUR_NIL: begin
          cur_r <= NIL;
        end
        cle_pkg::U_CLEAR: begin
          head_r <= NIL;
          tail_r <= NIL;
          cur_r  <= NIL;
          cnt_r  <= '0;
          hwm_r  <= '0;
          sp_r   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign val_ext  = {{64{in_value[31]}}, in_value};
  assign cnt_ext  = {8'b0, cnt_r};
  assign cidx_ext = {8'b0, cidx_r};
  assign fv_ext   = {{32{fv_r[DW-1]}}, fv_r};
  assign bv_ext   = {{32{bv_r[DW-1]}}, bv_r};
  assign cv_ext   = {{32{cv_r[DW-1]}}, cv_r};

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      val_r <= val_ext[DW-1:0];
    end
    if (cmd.alloc) begin
      slot_r <= (sp_r != '0) ? LW'(fs_q) : hwm_r;
    end
    if (cmd.cap) begin
      pn_r <= pv_q;
      nn_r <= nx_q;
    end
    if (cmd.st_we)     st_r <= cmd.st;
    if (cmd.cap_front) fv_r <= data_q;
    if (cmd.cap_back)  bv_r <= data_q;
    if (cmd.cap_cur)   cv_r <= data_q;
    if (cmd.publish) begin
      out_status_r <= st_r;
      out_count_r  <= cnt_ext[6:0];
      out_cpos_r   <= (cur_r != NIL) ? cidx_ext[6:0] : 7'h7F;
      out_fv_r     <= (cnt_r != '0) ? fv_ext[31:0] : 32'd0;
      out_bv_r     <= (cnt_r != '0) ? bv_ext[31:0] : 32'd0;
      out_cv_r     <= (cur_r != NIL) ? cv_ext[31:0] : 32'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_count        = out_count_r;
  assign out_cursor_pos   = out_cpos_r;
  assign out_front_value  = out_fv_r;
  assign out_back_value   = out_bv_r;
  assign out_cursor_value = out_cv_r;

endmodule

FILE: hdl/cle_ctrl.sv
// Controller of the cursor list engine: decodes each op, sequences node
// reads, link writes and the result readout. Uses cle_pkg.
module cle_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cle_pkg::flags_t flags,
  output cle_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_CAP, S_W1, S_W2, S_RD0, S_RD1, S_RD2, S_RD3, S_PUB
  } state_t;

  typedef enum logic [3:0] {
    P_NONE, P_PREPEND, P_APPEND, P_INS_B, P_INS_A,
    P_DEL_FRONT, P_DEL_BACK, P_DEL_MID, P_MV_PREV, P_MV_NEXT
  } plan_t;

  state_t state_r, state_nxt;
  plan_t  plan_r, plan_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plan_r  <= P_NONE;
    end else begin
      state_r <= state_nxt;
      plan_r  <= plan_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.st    = cle_pkg::ST_OK;
    state_nxt = state_r;
    plan_nxt  = plan_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.st_we = 1'b1;
        plan_nxt  = P_NONE;
        state_nxt = S_RD0;
        case (flags.op)
          cle_pkg::OP_PREPEND, cle_pkg::OP_APPEND: begin
            if (flags.full) begin
              cmd.st = cle_pkg::ST_FULL;
            end else begin
              cmd.alloc = 1'b1;
              plan_nxt  = (flags.op == cle_pkg::OP_PREPEND) ? P_PREPEND : P_APPEND;
              state_nxt = S_W1;
            end
          end
          cle_pkg::OP_INS_B, cle_pkg::OP_INS_A: begin
            if (flags.empty) begin
              cmd.st = cle_pkg::ST_EMPTY;
            end else if (flags.nocur) begin
              cmd.st = cle_pkg::ST_NOCUR;
            end else if (flags.full) begin
              cmd.st = cle_pkg::ST_FULL;
            end else begin
              cmd.alloc  = 1'b1;
              cmd.rd_sel = cle_pkg::LS_CUR;
              if (flags.op == cle_pkg::OP_INS_B) begin
                plan_nxt  = flags.cur_head ? P_PREPEND : P_INS_B;
                state_nxt = flags.cur_head ? S_W1 : S_CAP;
              end else begin
                plan_nxt  = flags.cur_tail ? P_APPEND : P_INS_A;
                state_nxt = flags.cur_tail ? S_W1 : S_CAP;
              end
            end
          end
          cle_pkg::OP_DEL_FRONT: begin
            if (flags.empty) begin
              cmd.st = cle_pkg::ST_EMPTY;
            end else begin
              cmd.rd_sel = cle_pkg::LS_HEAD;
              plan_nxt   = P_DEL_FRONT;
              state_nxt  = S_CAP;
            end
          end
          cle_pkg::OP_DEL_BACK: begin
            if (flags.empty) begin
              cmd.st = cle_pkg::ST_EMPTY;
            end else begin
              cmd.rd_sel = cle_pkg::LS_TAIL;
              plan_nxt   = P_DEL_BACK;
              state_nxt  = S_CAP;
            end
          end
          cle_pkg::OP_DEL_CUR: begin
            if (flags.empty) begin
              cmd.st = cle_pkg::ST_EMPTY;
            end else if (flags.nocur) begin
              cmd.st = cle_pkg::ST_NOCUR;
            end else begin
              state_nxt = S_CAP;
              if (flags.cur_head) begin
                cmd.rd_sel = cle_pkg::LS_HEAD;
                plan_nxt   = P_DEL_FRONT;
              end else if (flags.cur_tail) begin
                cmd.rd_sel = cle_pkg::LS_TAIL;
                plan_nxt   = P_DEL_BACK;
              end else begin
                cmd.rd_sel = cle_pkg::LS_CUR;
                plan_nxt   = P_DEL_MID;
              end
            end
          end
          cle_pkg::OP_MV_FRONT: begin
            if (!flags.empty) cmd.upd = cle_pkg::U_MV_FRONT;
          end
          cle_pkg::OP_MV_BACK: begin
            if (!flags.empty) cmd.upd = cle_pkg::U_MV_BACK;
          end
          cle_pkg::OP_MV_PREV, cle_pkg::OP_MV_NEXT: begin
            if (!flags.nocur) begin
              if ((flags.op == cle_pkg::OP_MV_PREV) ? flags.cidx_zero : flags.cidx_last) begin
                cmd.upd = cle_pkg::U_CUR_NIL;
              end else begin
                cmd.rd_sel = cle_pkg::LS_CUR;
                plan_nxt   = (flags.op == cle_pkg::OP_MV_PREV) ? P_MV_PREV : P_MV_NEXT;
                state_nxt  = S_CAP;
              end
            end
          end
          cle_pkg::OP_SET: begin
            if (flags.empty) begin
              cmd.st = cle_pkg::ST_EMPTY;
            end else if (flags.nocur) begin
              cmd.st = cle_pkg::ST_NOCUR;
            end else begin
              cmd.dwe    = 1'b1;
              cmd.dw_sel = cle_pkg::LS_CUR;
            end
          end
          cle_pkg::OP_CLEAR: begin
            cmd.upd = cle_pkg::U_CLEAR;
          end
          default: begin
          end
        endcase
      end
      S_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = S_W2;
        case (plan_r)
          P_INS_B, P_INS_A: state_nxt = S_W1;
          P_MV_PREV: begin
            cmd.upd   = cle_pkg::U_MV_PREV;
            state_nxt = S_RD0;
          end
          P_MV_NEXT: begin
            cmd.upd   = cle_pkg::U_MV_NEXT;
            state_nxt = S_RD0;
          end
          default: begin
          end
        endcase
      end
      S_W1: begin
        cmd.dwe     = 1'b1;
        cmd.dw_sel  = cle_pkg::LS_SLOT;
        cmd.nwe     = 1'b1;
        cmd.nw_addr = cle_pkg::LS_SLOT;
        cmd.pwe     = 1'b1;
        cmd.pw_addr = cle_pkg::LS_SLOT;
        state_nxt   = S_W2;
        case (plan_r)
          P_PREPEND: begin
            cmd.nw_data = cle_pkg::LS_HEAD;
            cmd.pw_data = cle_pkg::LS_NIL;
          end
          P_APPEND: begin
            cmd.nw_data = cle_pkg::LS_NIL;
            cmd.pw_data = cle_pkg::LS_TAIL;
          end
          P_INS_B: begin
            cmd.nw_data = cle_pkg::LS_CUR;
            cmd.pw_data = cle_pkg::LS_PN;
          end
          default: begin
            cmd.nw_data = cle_pkg::LS_NN;
            cmd.pw_data = cle_pkg::LS_CUR;
          end
        endcase
      end
      S_W2: begin
        state_nxt = S_RD0;
        case (plan_r)
          P_PREPEND: begin
            cmd.pwe     = !flags.empty;
            cmd.pw_addr = cle_pkg::LS_HEAD;
            cmd.pw_data = cle_pkg::LS_SLOT;
            cmd.upd     = cle_pkg::U_PREPEND;
          end
          P_APPEND: begin
            cmd.nwe     = !flags.empty;
            cmd.nw_addr = cle_pkg::LS_TAIL;
            cmd.nw_data = cle_pkg::LS_SLOT;
            cmd.upd     = cle_pkg::U_APPEND;
          end
          P_INS_B: begin
            cmd.nwe     = 1'b1;
            cmd.nw_addr = cle_pkg::LS_PN;
            cmd.nw_data = cle_pkg::LS_SLOT;
            cmd.pwe     = 1'b1;
            cmd.pw_addr = cle_pkg::LS_CUR;
            cmd.pw_data = cle_pkg::LS_SLOT;
            cmd.upd     = cle_pkg::U_INS_B;
          end
          P_INS_A: begin
            cmd.pwe     = 1'b1;
            cmd.pw_addr = cle_pkg::LS_NN;
            cmd.pw_data = cle_pkg::LS_SLOT;
            cmd.nwe     = 1'b1;
            cmd.nw_addr = cle_pkg::LS_CUR;
            cmd.nw_data = cle_pkg::LS_SLOT;
            cmd.upd     = cle_pkg::U_INS_A;
          end
          P_DEL_FRONT: begin
            cmd.pwe      = !flags.one;
            cmd.pw_addr  = cle_pkg::LS_NN;
            cmd.pw_data  = cle_pkg::LS_NIL;
            cmd.free_en  = 1'b1;
            cmd.free_sel = cle_pkg::LS_HEAD;
            cmd.upd      = cle_pkg::U_DEL_FRONT;
          end
          P_DEL_BACK: begin
            cmd.nwe      = !flags.one;
            cmd.nw_addr  = cle_pkg::LS_PN;
            cmd.nw_data  = cle_pkg::LS_NIL;
            cmd.free_en  = 1'b1;
            cmd.free_sel = cle_pkg::LS_TAIL;
            cmd.upd      = cle_pkg::U_DEL_BACK;
          end
          P_DEL_MID: begin
            cmd.nwe      = 1'b1;
            cmd.nw_addr  = cle_pkg::LS_PN;
            cmd.nw_data  = cle_pkg::LS_NN;
            cmd.pwe      = 1'b1;
            cmd.pw_addr  = cle_pkg::LS_NN;
            cmd.pw_data  = cle_pkg::LS_PN;
            cmd.free_en  = 1'b1;
            cmd.free_sel = cle_pkg::LS_CUR;
            cmd.upd      = cle_pkg::U_DEL_MID;
          end
          default: begin
          end
        endcase
      end
      S_RD0: begin
        cmd.drd_sel = cle_pkg::LS_HEAD;
        state_nxt   = S_RD1;
      end
      S_RD1: begin
        cmd.drd_sel   = cle_pkg::LS_TAIL;
        cmd.cap_front = 1'b1;
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        cmd.drd_sel  = cle_pkg::LS_CUR;
        cmd.cap_back = 1'b1;
        state_nxt    = S_RD3;
      end
      S_RD3: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = S_PUB;
      end
      S_PUB: begin
        if (!flags.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/cursor_list_engine.sv
// Cursor list engine top level: one op in, one result out per transfer.
// Each op passes through decode, up to three link read/write steps on the
// node memories, then a three-read readout, before its result is published.
// A new op is accepted only once the previous result has been published; the
// controller stalls the input while it works and while the output is stalled.
// Synchronous active-low reset empties the list; node memories are not cleared.
// Depends on cle_pkg, cle_ctrl, cle_datapath and cursor_list_engine_defines.svh.
`include "cursor_list_engine_defines.svh"
module cursor_list_engine #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [6:0]         out_count,
  output logic signed [6:0]  out_cursor_pos,
  output logic signed [31:0] out_front_value,
  output logic signed [31:0] out_back_value,
  output logic signed [31:0] out_cursor_value
);

  cle_pkg::cmd_t   cmd;
  cle_pkg::flags_t flags;

  cle_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .flags, .cmd
  );

  cle_datapath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .flags, .in_op, .in_value, .out_stall, .out_valid,
    .out_status, .out_count, .out_cursor_pos, .out_front_value,
    .out_back_value, .out_cursor_value
  );

  `CLE_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "accepted while busy")
  `CLE_ASSERT_NOW(a_no_alloc_when_full, cmd.alloc, !flags.full, "slot taken from full store")
  `CLE_ASSERT_NOW(a_publish_free, cmd.publish, !(out_valid && out_stall), "result overwritten")

endmodule

FILE: dv/cursor_list_engine_tb.sv
// Self-checking testbench for cursor_list_engine: drives list operations,
// predicts each result with a behavioral list model and compares every field.
// Depends on cle_pkg and the cursor_list_engine RTL.
`timescale 1ns / 100ps
module cursor_list_engine_tb;

  localparam int NSLOT = 64;
  localparam int NIL   = NSLOT;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] value;
  } list_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [6:0]  cursor_pos;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [31:0] cursor_value;
  } list_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_op = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [6:0] out_count;
  logic signed [6:0] out_cursor_pos;
  logic signed [31:0] out_front_value, out_back_value, out_cursor_value;

  cursor_list_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_count(out_count), .out_cursor_pos(out_cursor_pos),
    .out_front_value(out_front_value), .out_back_value(out_back_value),
    .out_cursor_value(out_cursor_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // list model state
  logic [31:0] m_data [NSLOT];
  int m_next [NSLOT];
  int m_prev [NSLOT];
  bit m_used [NSLOT];
  int m_head, m_tail, m_cur, m_len, m_idx;

  list_op_t   pending_ops[$];
  list_view_t expected_views[$];
  int n_sent, n_checked, n_errors, n_full, n_shown;
  bit quiet_tail;

  function automatic void list_clear();
    for (int i = 0; i < NSLOT; i++) m_used[i] = 1'b0;
    m_head = NIL; m_tail = NIL; m_cur = NIL; m_len = 0; m_idx = -1;
  endfunction

  function automatic int grab_slot(logic [31:0] v);
    for (int i = 0; i < NSLOT; i++)
      if (!m_used[i]) begin
        m_used[i] = 1'b1; m_data[i] = v; m_next[i] = NIL; m_prev[i] = NIL;
        return i;
      end
    return NIL;
  endfunction

  function automatic void list_prepend(logic [31:0] v);
    int s;
    s = grab_slot(v);
    m_next[s] = m_head;
    if (m_len != 0) m_prev[m_head] = s; else m_tail = s;
    m_head = s;
    if (m_cur != NIL) m_idx++;
    m_len++;
  endfunction

  function automatic void list_append(logic [31:0] v);
    int s;
    s = grab_slot(v);
    m_prev[s] = m_tail;
    if (m_len != 0) m_next[m_tail] = s; else m_head = s;
    m_tail = s;
    m_len++;
  endfunction

  function automatic void list_del_front();
    int n;
    n = m_head;
    if (m_cur == m_head) begin m_cur = NIL; m_idx = -1; end
    else if (m_cur != NIL) m_idx--;
    if (m_len > 1) begin m_head = m_next[n]; m_prev[m_head] = NIL; end
    else begin m_head = NIL; m_tail = NIL; end
    m_used[n] = 1'b0;
    m_len--;
  endfunction

  function automatic void list_del_back();
    int n;
    n = m_tail;
    if (m_cur == m_tail) begin m_cur = NIL; m_idx = -1; end
    if (m_len > 1) begin m_tail = m_prev[n]; m_next[m_tail] = NIL; end
    else begin m_head = NIL; m_tail = NIL; end
    m_used[n] = 1'b0;
    m_len--;
  endfunction

  function automatic list_view_t apply_list_op(list_op_t it);
    list_view_t r;
    bit empty, nocur, full;
    int c, s;
    cle_pkg::status_t st;
    empty = (m_len == 0); nocur = (m_cur == NIL); full = (m_len >= NSLOT);
    c = m_cur;
    st = cle_pkg::ST_OK;
    case (it.op)
      cle_pkg::OP_PREPEND:
        if (full) st = cle_pkg::ST_FULL; else list_prepend(it.value);
      cle_pkg::OP_APPEND:
        if (full) st = cle_pkg::ST_FULL; else list_append(it.value);
      cle_pkg::OP_INS_B: begin
        if (empty) st = cle_pkg::ST_EMPTY; else if (nocur) st = cle_pkg::ST_NOCUR;
        else if (full) st = cle_pkg::ST_FULL;
        else if (c == m_head) list_prepend(it.value);
        else begin
          s = grab_slot(it.value);
          m_next[s] = c; m_prev[s] = m_prev[c];
          m_next[m_prev[c]] = s; m_prev[c] = s;
          m_idx++; m_len++;
        end
      end
      cle_pkg::OP_INS_A: begin
        if (empty) st = cle_pkg::ST_EMPTY; else if (nocur) st = cle_pkg::ST_NOCUR;
        else if (full) st = cle_pkg::ST_FULL;
        else if (c == m_tail) list_append(it.value);
        else begin
          s = grab_slot(it.value);
          m_prev[s] = c; m_next[s] = m_next[c];
          m_prev[m_next[c]] = s; m_next[c] = s;
          m_len++;
        end
      end
      cle_pkg::OP_DEL_FRONT: if (empty) st = cle_pkg::ST_EMPTY; else list_del_front();
      cle_pkg::OP_DEL_BACK:  if (empty) st = cle_pkg::ST_EMPTY; else list_del_back();
      cle_pkg::OP_DEL_CUR: begin
        if (empty) st = cle_pkg::ST_EMPTY; else if (nocur) st = cle_pkg::ST_NOCUR;
        else if (c == m_head) list_del_front();
        else if (c == m_tail) list_del_back();
        else begin
          m_next[m_prev[c]] = m_next[c];
          m_prev[m_next[c]] = m_prev[c];
          m_used[c] = 1'b0; m_len--;
          m_cur = NIL; m_idx = -1;
        end
      end
      cle_pkg::OP_MV_FRONT: if (!empty) begin m_cur = m_head; m_idx = 0; end
      cle_pkg::OP_MV_BACK:  if (!empty) begin m_cur = m_tail; m_idx = m_len - 1; end
      cle_pkg::OP_MV_PREV: if (!nocur) begin
        if (m_idx != 0) begin m_cur = m_prev[c]; m_idx--; end
        else begin m_cur = NIL; m_idx = -1; end
      end
      cle_pkg::OP_MV_NEXT: if (!nocur) begin
        if (m_idx != m_len - 1) begin m_cur = m_next[c]; m_idx++; end
        else begin m_cur = NIL; m_idx = -1; end
      end
      cle_pkg::OP_SET: begin
        if (empty) st = cle_pkg::ST_EMPTY; else if (nocur) st = cle_pkg::ST_NOCUR;
        else m_data[c] = it.value;
      end
      cle_pkg::OP_CLEAR: list_clear();
      default: ;
    endcase
    if (st == cle_pkg::ST_FULL) n_full++;
    r.status       = st;
    r.count        = m_len[6:0];
    r.cursor_pos   = m_idx[6:0];
    r.front_value  = (m_len != 0) ? m_data[m_head] : '0;
    r.back_value   = (m_len != 0) ? m_data[m_tail] : '0;
    r.cursor_value = (m_cur != NIL) ? m_data[m_cur] : '0;
    return r;
  endfunction

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_views.push_back(apply_list_op({in_op, in_value}));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0 && (quiet_tail || $urandom_range(9) != 0)) begin
          list_op_t it;
          it = pending_ops.pop_front();
          in_valid <= 1'b1; in_op <= it.op; in_value <= it.value;
        end else begin
          in_valid <= 1'b0;
          if (!quiet_tail && pending_ops.size() != 0) in_gap = $urandom_range(6, 1) - 1;
        end
      end
    end
  end

  // monitor
  int stall_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        list_view_t got, exp_v;
        got = {out_status, out_count, out_cursor_pos, out_front_value,
               out_back_value, out_cursor_value};
        if (expected_views.size() == 0) begin
          n_errors++;
          if (n_shown++ < 10) $display("unexpected result transfer: %p", got);
        end else begin
          exp_v = expected_views.pop_front();
          n_checked++;
          if (got !== exp_v) begin
            n_errors++;
            if (n_shown++ < 10)
              $display("mismatch on result %0d: expected %p, actual %p",
                       n_checked, exp_v, got);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(6, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(cle_pkg::op_t o, logic [31:0] v);
    pending_ops.push_back({o, v});
  endtask

  initial begin
    list_op_t it;
    int k;
    list_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty-list errors, idle moves and undefined op codes
    queue_op(cle_pkg::OP_DEL_FRONT, 0); queue_op(cle_pkg::OP_DEL_BACK, 0);
    queue_op(cle_pkg::OP_DEL_CUR, 0);
    queue_op(cle_pkg::OP_SET, 1); queue_op(cle_pkg::OP_INS_B, 2);
    queue_op(cle_pkg::OP_INS_A, 3);
    queue_op(cle_pkg::OP_MV_FRONT, 0); queue_op(cle_pkg::OP_MV_PREV, 0);
    pending_ops.push_back({4'd13, 32'h0}); pending_ops.push_back({4'd15, 32'hFFFF_FFFF});
    // build, cursor errors, edges of cursor motion
    queue_op(cle_pkg::OP_APPEND, 32'h8000_0000); queue_op(cle_pkg::OP_PREPEND, 32'h7FFF_FFFF);
    queue_op(cle_pkg::OP_INS_B, 5); queue_op(cle_pkg::OP_SET, 6);
    queue_op(cle_pkg::OP_DEL_CUR, 0);
    queue_op(cle_pkg::OP_MV_FRONT, 0); queue_op(cle_pkg::OP_MV_PREV, 0);
    queue_op(cle_pkg::OP_MV_BACK, 0); queue_op(cle_pkg::OP_MV_NEXT, 0);
    queue_op(cle_pkg::OP_MV_FRONT, 0); queue_op(cle_pkg::OP_INS_A, 32'hFFFF_FFFF);
    queue_op(cle_pkg::OP_MV_NEXT, 0); queue_op(cle_pkg::OP_INS_B, 7);
    queue_op(cle_pkg::OP_DEL_CUR, 0);
    queue_op(cle_pkg::OP_CLEAR, 0);

    // fill to capacity, then hit the full store
    for (int i = 0; i < NSLOT; i++)
      queue_op(i[0] ? cle_pkg::OP_APPEND : cle_pkg::OP_PREPEND, rand_word());
    queue_op(cle_pkg::OP_PREPEND, 1); queue_op(cle_pkg::OP_APPEND, 2);
    queue_op(cle_pkg::OP_MV_FRONT, 0);
    queue_op(cle_pkg::OP_INS_B, 3); queue_op(cle_pkg::OP_INS_A, 4);
    queue_op(cle_pkg::OP_SET, 32'h8000_0000);
    for (int i = 0; i < 20; i++) queue_op(cle_pkg::OP_DEL_CUR, 0);
    queue_op(cle_pkg::OP_CLEAR, 0);

    // random: mostly cursor-rich traffic, some bursts that refill the store
    k = 0;
    while (k < 1800) begin
      if ($urandom_range(99) < 3) begin
        for (int i = 0; i < 66; i++) begin
          queue_op(cle_pkg::op_t'(4'($urandom_range(3))), rand_word());
          if ($urandom_range(3) == 0) queue_op(cle_pkg::OP_MV_NEXT, 0);
        end
        k += 80;
      end else begin
        it.value = rand_word();
        case ($urandom_range(99))
          0:  it.op = 4'(13 + $urandom_range(2));
          1:  it.op = cle_pkg::OP_CLEAR;
          default: it.op = 4'($urandom_range(11));
        endcase
        pending_ops.push_back(it);
        k++;
      end
    end

    while (pending_ops.size() >= 200) @(posedge clk);
    quiet_tail = 1'b1;
    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d list operations, checked %0d results, %0d full-store rejects.",
             n_sent, n_checked, n_full);
    if (n_errors == 0 && expected_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_views.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/cle_pkg.sv
hdl/cle_ram.sv
hdl/cle_datapath.sv
hdl/cle_ctrl.sv
hdl/cursor_list_engine.sv
dv/cursor_list_engine_tb.sv
